// ----- hdl/sha_pkg.sv -----
// SHA-256 engine package: initial hash values, round constants, state codes.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package sha_pkg;

  localparam logic [7:0] PAD_BYTE = 8'h80;

  typedef logic [31:0] word_t;

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_LOAD  = 7'b0000010,
    ST_ROUND = 7'b0000100,
    ST_FOLD  = 7'b0001000,
    ST_PAD   = 7'b0010000,
    ST_EMIT  = 7'b0100000,
    ST_ERR   = 7'b1000000
  } state_t;

  function automatic word_t hash_init(input logic [2:0] i);
    word_t r;
    case (i)
      3'd0: r = 32'h6a09e667;
      3'd1: r = 32'hbb67ae85;
      3'd2: r = 32'h3c6ef372;
      3'd3: r = 32'ha54ff53a;
      3'd4: r = 32'h510e527f;
      3'd5: r = 32'h9b05688c;
      3'd6: r = 32'h1f83d9ab;
      default: r = 32'h5be0cd19;
    endcase
    return r;
  endfunction

  localparam word_t ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

endpackage
`default_nettype wire

// ----- hdl/sha_if.sv -----
// Valid/ready channel interfaces for the SHA-256 engine.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
interface sha_in_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] data_byte;
  modport source (output valid, kind, data_byte, input ready);
  modport sink (input valid, kind, data_byte, output ready);
endinterface

interface sha_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic        last_word;
  logic        error;
  modport source (output valid, digest_word, last_word, error, input ready);
  modport sink (input valid, digest_word, last_word, error, output ready);
endinterface
`default_nettype wire

// ----- hdl/sha256_hash_engine.sv -----
// SHA-256 engine top level: byte packer, sequencer, hash state, output.
// Uses sha_pkg, sha_if, sha_ram, sha_round.
// Input: bytes are taken only in the idle state; the 64th byte starts a
// compression (64 rounds on one shared round unit, a 16-word schedule
// window, a fold). Finish: 1 or 2 compressions plus padding, then 8 output
// transfers. Sync reset restores the initial hash.
`timescale 1ns / 1ps
`default_nettype none
module sha256_hash_engine (
  input wire logic clk,
  input wire logic rst,
  sha_in_if.sink   in_ch,
  sha_out_if.source out_ch
);
  sha_pkg::state_t state;
  sha_pkg::word_t  hash [8];
  sha_pkg::word_t  v [8];
  sha_pkg::word_t  v_nx [8];
  sha_pkg::word_t  win [16];
  sha_pkg::word_t  w_new, w_cur;
  logic [5:0]  fill_count;
  logic [63:0] bit_length;
  logic        length_error;
  logic [6:0]  round;
  logic        finishing, second;
  logic [2:0]  emit_idx;
  logic        ram_we;
  logic [3:0]  ram_addr;
  sha_pkg::word_t ram_wdata, ram_rdata, wacc;
  logic [5:0]  pad_pos;

  // block words are packed into a 16-word RAM; rounds read it in sequence
  sha_ram #(.WIDTH(32), .DEPTH(16)) u_blk (
    .clk(clk), .we(ram_we), .addr(ram_addr), .wdata(ram_wdata), .rdata(ram_rdata)
  );

  assign w_cur = (round < 7'd16) ? ram_rdata : w_new;

  sha_round u_rnd (
    .v_in(v), .k(sha_pkg::ROUND_K[round[5:0]]), .w(w_cur), .v_out(v_nx),
    .w2(win[14]), .w7(win[9]), .w15(win[1]), .w16(win[0]), .w_new(w_new)
  );

  // pad byte at pad_pos for the finish path
  logic [7:0] pad_byte;
  always_comb begin
    if (!second && pad_pos == fill_count) pad_byte = sha_pkg::PAD_BYTE;
    else if (pad_pos >= 6'd56 && (second || fill_count < 6'd56))
      pad_byte = bit_length[8*(6'd63 - pad_pos) +: 8];
    else pad_byte = 8'h00;
  end

  logic [5:0] wpos;
  logic [7:0] wbyte;
  always_comb begin
    wpos = (state == sha_pkg::ST_PAD) ? pad_pos : fill_count;
    wbyte = (state == sha_pkg::ST_PAD) ? pad_byte : in_ch.data_byte;
    ram_wdata = {wacc[23:0], wbyte};
    ram_we = ((state == sha_pkg::ST_IDLE && in_ch.valid && !in_ch.kind &&
               !length_error && bit_length <= 64'hFFFF_FFFF_FFFF_FFF7) ||
              state == sha_pkg::ST_PAD) && wpos[1:0] == 2'd3;
    if (state == sha_pkg::ST_LOAD || state == sha_pkg::ST_ROUND)
      ram_addr = (state == sha_pkg::ST_LOAD) ? 4'd0 : 4'(round + 7'd1);
    else ram_addr = wpos[5:2];
  end

  assign in_ch.ready = (state == sha_pkg::ST_IDLE);
  assign out_ch.valid = (state == sha_pkg::ST_EMIT) || (state == sha_pkg::ST_ERR);
  assign out_ch.digest_word = (state == sha_pkg::ST_ERR) ? 32'd0 : hash[emit_idx];
  assign out_ch.last_word = (state == sha_pkg::ST_ERR) || (emit_idx == 3'd7);
  assign out_ch.error = (state == sha_pkg::ST_ERR);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sha_pkg::ST_IDLE;
      for (int i = 0; i < 8; i++) hash[i] <= sha_pkg::hash_init(3'(i));
      fill_count <= '0;
      bit_length <= '0;
      length_error <= 1'b0;
      finishing <= 1'b0;
      second <= 1'b0;
      emit_idx <= '0;
      round <= '0;
      pad_pos <= '0;
    end else begin
      case (state)
        sha_pkg::ST_IDLE: begin
          if (in_ch.valid) begin
            if (in_ch.kind) begin
              if (length_error) state <= sha_pkg::ST_ERR;
              else begin
                state <= sha_pkg::ST_PAD;
                finishing <= 1'b1;
                second <= 1'b0;
                pad_pos <= fill_count;
              end
            end else if (!length_error) begin
              if (bit_length > 64'hFFFF_FFFF_FFFF_FFF7) length_error <= 1'b1;
              else begin
                wacc <= ram_wdata;
                bit_length <= bit_length + 64'd8;
                fill_count <= fill_count + 6'd1;
                if (fill_count == 6'd63) begin
                  state <= sha_pkg::ST_LOAD;
                  finishing <= 1'b0;
                end
              end
            end
          end
        end
        sha_pkg::ST_PAD: begin
          wacc <= ram_wdata;
          pad_pos <= pad_pos + 6'd1;
          if (pad_pos == 6'd63) state <= sha_pkg::ST_LOAD;
        end
        sha_pkg::ST_LOAD: begin
          for (int i = 0; i < 8; i++) v[i] <= hash[i];
          round <= '0;
          state <= sha_pkg::ST_ROUND;
        end
        sha_pkg::ST_ROUND: begin
          for (int i = 0; i < 8; i++) v[i] <= v_nx[i];
          for (int i = 0; i < 15; i++) win[i] <= win[i+1];
          win[15] <= w_cur;
          round <= round + 7'd1;
          if (round == 7'd63) state <= sha_pkg::ST_FOLD;
        end
        sha_pkg::ST_FOLD: begin
          for (int i = 0; i < 8; i++) hash[i] <= hash[i] + v[i];
          if (!finishing) state <= sha_pkg::ST_IDLE;
          else if (!second && fill_count >= 6'd56) begin
            second <= 1'b1;
            pad_pos <= '0;
            wacc <= '0;
            state <= sha_pkg::ST_PAD;
          end else begin
            emit_idx <= '0;
            state <= sha_pkg::ST_EMIT;
          end
        end
        sha_pkg::ST_EMIT: begin
          if (out_ch.ready) begin
            emit_idx <= emit_idx + 3'd1;
            if (emit_idx == 3'd7) begin
              state <= sha_pkg::ST_IDLE;
              for (int i = 0; i < 8; i++) hash[i] <= sha_pkg::hash_init(3'(i));
              fill_count <= '0;
              bit_length <= '0;
              finishing <= 1'b0;
            end
          end
        end
        sha_pkg::ST_ERR: begin
          if (out_ch.ready) begin
            state <= sha_pkg::ST_IDLE;
            for (int i = 0; i < 8; i++) hash[i] <= sha_pkg::hash_init(3'(i));
            fill_count <= '0;
            bit_length <= '0;
            length_error <= 1'b0;
          end
        end
        default: state <= sha_pkg::ST_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

// ----- hdl/sha_ram.sv -----
// Generic single-port RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module sha_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule
`default_nettype wire

// ----- hdl/sha_round.sv -----
// One SHA-256 round: working-variable update and schedule word expansion.
// Uses sha_pkg.
`timescale 1ns / 1ps
`default_nettype none
module sha_round (
  input  wire sha_pkg::word_t v_in  [8],
  input  wire sha_pkg::word_t k,
  input  wire sha_pkg::word_t w,
  output sha_pkg::word_t      v_out [8],
  input  wire sha_pkg::word_t w2,
  input  wire sha_pkg::word_t w7,
  input  wire sha_pkg::word_t w15,
  input  wire sha_pkg::word_t w16,
  output sha_pkg::word_t      w_new
);
  sha_pkg::word_t s1, ch, t1, s0, mj, g0, g1;
  always_comb begin
    s1 = {v_in[4][5:0], v_in[4][31:6]} ^ {v_in[4][10:0], v_in[4][31:11]}
       ^ {v_in[4][24:0], v_in[4][31:25]};
    ch = (v_in[4] & v_in[5]) ^ (~v_in[4] & v_in[6]);
    t1 = v_in[7] + s1 + ch + k + w;
    s0 = {v_in[0][1:0], v_in[0][31:2]} ^ {v_in[0][12:0], v_in[0][31:13]}
       ^ {v_in[0][21:0], v_in[0][31:22]};
    mj = (v_in[0] & v_in[1]) ^ (v_in[0] & v_in[2]) ^ (v_in[1] & v_in[2]);
    v_out[7] = v_in[6];
    v_out[6] = v_in[5];
    v_out[5] = v_in[4];
    v_out[4] = v_in[3] + t1;
    v_out[3] = v_in[2];
    v_out[2] = v_in[1];
    v_out[1] = v_in[0];
    v_out[0] = t1 + s0 + mj;
    g1 = {w2[16:0], w2[31:17]} ^ {w2[18:0], w2[31:19]} ^ (w2 >> 10);
    g0 = {w15[6:0], w15[31:7]} ^ {w15[17:0], w15[31:18]} ^ (w15 >> 3);
    w_new = g1 + w7 + g0 + w16;
  end
endmodule
`default_nettype wire

// ----- verif/sha256_hash_engine_test.sv -----
// Self-checking testbench for sha256_hash_engine: byte/finish transfers in,
// digest words out, checked against an in-bench SHA-256 digest predictor.
// Depends on sha_if from hdl/.
`timescale 1ns / 1ps

typedef struct packed {
  logic [31:0] word;
  logic        last;
  logic        err;
} digest_result_t;

localparam logic KIND_BYTE   = 1'b0;
localparam logic KIND_FINISH = 1'b1;

class digest_scoreboard;
  localparam logic [31:0] IV [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };
  localparam logic [31:0] KTAB [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  logic [31:0]    hash [8];
  logic [7:0]     blk [64];
  logic [31:0]    sched [16];
  int unsigned    fill;
  logic [63:0]    nbits;
  logic           len_err;
  digest_result_t digest_q [$];
  int             mismatches;

  function new();
    mismatches = 0;
    restart();
  endfunction

  function void restart();
    for (int i = 0; i < 8; i++) hash[i] = IV[i];
    fill = 0;
    nbits = '0;
    len_err = 1'b0;
  endfunction

  function logic [31:0] rotr(logic [31:0] x, int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function void compress();
    logic [31:0] v [8];
    logic [31:0] w, s1, ch, t1, s0, mj, a2, a15;
    for (int i = 0; i < 8; i++) v[i] = hash[i];
    for (int t = 0; t < 64; t++) begin
      if (t < 16) begin
        w = {blk[4*t], blk[4*t+1], blk[4*t+2], blk[4*t+3]};
      end else begin
        a2 = sched[(t-2) & 15];
        a15 = sched[(t-15) & 15];
        w = (rotr(a2, 17) ^ rotr(a2, 19) ^ (a2 >> 10)) + sched[(t-7) & 15] +
            (rotr(a15, 7) ^ rotr(a15, 18) ^ (a15 >> 3)) + sched[t & 15];
      end
      sched[t & 15] = w;
      s1 = rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25);
      ch = (v[4] & v[5]) ^ (~v[4] & v[6]);
      t1 = v[7] + s1 + ch + KTAB[t] + w;
      s0 = rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22);
      mj = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4];
      v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0];
      v[0] = t1 + s0 + mj;
    end
    for (int i = 0; i < 8; i++) hash[i] = hash[i] + v[i];
  endfunction

  function void note_input(logic kind, logic [7:0] data);
    int unsigned n;
    digest_result_t r;
    if (kind == KIND_BYTE) begin
      if (len_err) return;
      if (nbits > 64'hffff_ffff_ffff_fff7) begin
        len_err = 1'b1;
        return;
      end
      blk[fill] = data;
      nbits = nbits + 64'd8;
      fill = (fill + 1) & 63;
      if (fill == 0) compress();
      return;
    end
    if (len_err) begin
      r.word = '0; r.last = 1'b1; r.err = 1'b1;
      digest_q.push_back(r);
      restart();
      return;
    end
    n = fill;
    blk[n] = 8'h80;
    n++;
    if (n > 56) begin
      while (n < 64) begin blk[n] = 8'h00; n++; end
      compress();
      n = 0;
    end
    while (n < 56) begin blk[n] = 8'h00; n++; end
    for (int i = 0; i < 8; i++) blk[56+i] = nbits[63-8*i -: 8];
    compress();
    for (int i = 0; i < 8; i++) begin
      r.word = hash[i]; r.last = (i == 7); r.err = 1'b0;
      digest_q.push_back(r);
    end
    restart();
  endfunction

  function void check_result(logic [31:0] word, logic last, logic err);
    digest_result_t e;
    if (digest_q.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("unexpected transfer: word=%h last=%b error=%b", word, last, err);
      return;
    end
    e = digest_q.pop_front();
    if (word !== e.word || last !== e.last || err !== e.err) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch: exp word=%h last=%b error=%b, got word=%h last=%b error=%b",
                 e.word, e.last, e.err, word, last, err);
    end
  endfunction
endclass

module sha256_hash_engine_test;

  localparam int ITEM_TARGET = 400;
  localparam int QUIET_FROM  = 340;
  localparam int LONG_HOLD   = 400;
  localparam int CYCLE_LIMIT = 300000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   cycles = 0;
  int   sent = 0;
  bit   quiet = 1'b0;
  bit   hold_req = 1'b0;

  sha_in_if  in_ch ();
  sha_out_if out_ch ();

  digest_scoreboard sb = new();

  sha256_hash_engine dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.kind = KIND_BYTE;
    in_ch.data_byte = 8'h00;
    out_ch.ready = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_ch.valid && out_ch.ready)
      sb.check_result(out_ch.digest_word, out_ch.last_word, out_ch.error);
  end

  // receiver: random stalls, one long hold-off, none at the end
  initial begin
    int n;
    bit held;
    held = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_req && !held) begin
        held = 1'b1;
        out_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else if (!quiet && $urandom_range(0, 2) == 0) begin
        out_ch.ready <= 1'b0;
        n = $urandom_range(1, 13);
        repeat (n) @(posedge clk);
      end else begin
        out_ch.ready <= 1'b1;
        n = $urandom_range(1, 20);
        repeat (n) @(posedge clk);
      end
    end
  end

  task automatic send_item(logic kind, logic [7:0] data);
    int n;
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_ch.valid <= 1'b0;
      n = $urandom_range(1, 13);
      repeat (n) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.kind <= kind;
    in_ch.data_byte <= data;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_input(kind, data);
    sent++;
    quiet = (sent >= QUIET_FROM);
    if (sent == 150) hold_req = 1'b1;
  endtask

  task automatic send_message(int len);
    for (int i = 0; i < len; i++) send_item(KIND_BYTE, 8'($urandom_range(0, 255)));
    send_item(KIND_FINISH, 8'($urandom_range(0, 255)));
  endtask

  task automatic drain_digests();
    while (sb.digest_q.size() != 0) @(posedge clk);
  endtask

  initial begin
    int len;
    bit paused;
    paused = 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // empty message, with a data byte on the finish transfer
    send_item(KIND_FINISH, 8'hff);
    // "abc"
    send_item(KIND_BYTE, 8'h61);
    send_item(KIND_BYTE, 8'h62);
    send_item(KIND_BYTE, 8'h63);
    send_item(KIND_FINISH, 8'h00);
    // byte extremes
    send_item(KIND_BYTE, 8'h00);
    send_item(KIND_BYTE, 8'hff);
    send_item(KIND_BYTE, 8'h80);
    send_item(KIND_BYTE, 8'h7f);
    send_item(KIND_FINISH, 8'h00);
    // back-to-back finishes
    send_item(KIND_FINISH, 8'h55);
    send_item(KIND_FINISH, 8'haa);

    while (sent < ITEM_TARGET) begin
      if (!paused && sent >= 250) begin
        paused = 1'b1;
        in_ch.valid <= 1'b0;
        @(posedge clk);
        drain_digests();
      end
      case ($urandom_range(0, 9))
        0, 1, 2: begin
          // padding boundaries: one or two final compressions, full blocks
          case ($urandom_range(0, 7))
            0: len = 55;
            1: len = 56;
            2: len = 57;
            3: len = 63;
            4: len = 64;
            5: len = 65;
            6: len = 119;
            default: len = 120;
          endcase
        end
        default: len = $urandom_range(0, 40);
      endcase
      send_message(len);
    end
    in_ch.valid <= 1'b0;
    @(posedge clk);
    drain_digests();
    repeat (200) @(posedge clk);
    if (sb.mismatches == 0 && sb.digest_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule
